// ----- rtl/mwsm_pkg.sv -----
// Package with the command, result and configuration types of the mecanum speed mixer.
package mwsm_pkg;

  localparam int WheelN  = 4;
  localparam int SpeedW  = 16;
  localparam int LimitW  = 15;
  localparam int RotW    = 16;
  localparam int RpmW    = 24;
  localparam int MagW    = 24;
  localparam int QuotW   = 15;
  localparam int NumW    = MagW + QuotW;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;

  typedef struct packed {
    logic signed [SpeedW-1:0] speed_sideways;
    logic signed [SpeedW-1:0] speed_forward;
    logic signed [SpeedW-1:0] speed_rotation;
  } cmd_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] rpm_front_right;
    logic signed [SpeedW-1:0] rpm_back_right;
    logic signed [SpeedW-1:0] rpm_back_left;
    logic signed [SpeedW-1:0] rpm_front_left;
  } result_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIMIT_SIDEWAYS = 3'd0,
    REG_LIMIT_FORWARD  = 3'd1,
    REG_LIMIT_ROTATION = 3'd2,
    REG_ROTATE_RATIO   = 3'd3,
    REG_RPM_RATIO      = 3'd4,
    REG_RPM_CAP        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LimitW-1:0] limit_sideways;
    logic [LimitW-1:0] limit_forward;
    logic [LimitW-1:0] limit_rotation;
    logic [RotW-1:0]   rotate_ratio;
    logic [RpmW-1:0]   rpm_ratio;
    logic [LimitW-1:0] rpm_cap;
  } cfg_t;

endpackage

// ----- rtl/mecanum_wheel_speed_mixer.sv -----
// Top level of the four-wheel mecanum speed mixer.
// The mixer takes one velocity command per clock cycle and returns the four
// wheel speeds with done high for exactly one cycle per command; the result beat
// travels through the 7-stage clamp, mixing, multiply and normalize front end,
// the 15-stage divider that scales the wheels to the rpm limit, and one output
// register. Since results cannot be held off, busy stays low and every command
// beat produces a result beat in the same order. Register writes take effect on
// the next cycle, so they belong to times when no command is in flight.
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cfg_t              cfg;
  logic              mag_valid;
  logic [MagW-1:0]   mag [WheelN];
  logic [WheelN-1:0] mag_neg;
  logic              num_valid;
  logic [NumW-1:0]   num [WheelN];
  logic [MagW-1:0]   den;
  logic [WheelN-1:0] num_neg;
  logic [WheelN-1:0] q_valid;
  logic [QuotW-1:0]  quot [WheelN];
  logic [WheelN-1:0] q_neg;
  logic [SpeedW-1:0] rpm [WheelN];

  assign busy = 1'b0;

  mwsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mwsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .cmd       (cmd),
    .cfg       (cfg),
    .mag_valid (mag_valid),
    .mag       (mag),
    .neg       (mag_neg)
  );

  mwsm_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .mag_valid (mag_valid),
    .mag       (mag),
    .neg       (mag_neg),
    .rpm_cap   (cfg.rpm_cap),
    .num_valid (num_valid),
    .num       (num),
    .den       (den),
    .num_neg   (num_neg)
  );

  for (genvar i = 0; i < WheelN; i++) begin : g_wheel
    mwsm_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (num_valid),
      .num       (num[i]),
      .den       (den),
      .in_neg    (num_neg[i]),
      .out_valid (q_valid[i]),
      .quot      (quot[i]),
      .out_neg   (q_neg[i])
    );

    assign rpm[i] = q_neg[i] ? -SpeedW'(quot[i]) : SpeedW'(quot[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    result.rpm_front_right <= rpm[0];
    result.rpm_back_right  <= rpm[1];
    result.rpm_back_left   <= rpm[2];
    result.rpm_front_left  <= rpm[3];
  end

endmodule

// ----- rtl/mwsm_cfg_regs.sv -----
// Configuration register file of the mecanum speed mixer.
module mwsm_cfg_regs
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_sideways <= LimitW'(3300);
      cfg.limit_forward  <= LimitW'(3300);
      cfg.limit_rotation <= LimitW'(300);
      cfg.rotate_ratio   <= RotW'(1024);
      cfg.rpm_ratio      <= RpmW'(110000);
      cfg.rpm_cap        <= LimitW'(8500);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIMIT_SIDEWAYS: cfg.limit_sideways <= cfg_data[LimitW-1:0];
        REG_LIMIT_FORWARD:  cfg.limit_forward  <= cfg_data[LimitW-1:0];
        REG_LIMIT_ROTATION: cfg.limit_rotation <= cfg_data[LimitW-1:0];
        REG_ROTATE_RATIO:   cfg.rotate_ratio   <= cfg_data[RotW-1:0];
        REG_RPM_RATIO:      cfg.rpm_ratio      <= cfg_data[RpmW-1:0];
        REG_RPM_CAP:        cfg.rpm_cap        <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/mwsm_front.sv -----
// Clamp, wheel mixing, magnitude and rpm scaling stages of the mecanum speed mixer.
module mwsm_front
  import mwsm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  cmd_t                 cmd,
  input  cfg_t                 cfg,
  output logic                 mag_valid,
  output logic [MagW-1:0]      mag [WheelN],
  output logic [WheelN-1:0]    neg
);

  function automatic logic signed [SpeedW-1:0] clamp_sym(logic signed [SpeedW-1:0] v,
                                                         logic [LimitW-1:0] lim);
    logic signed [SpeedW-1:0] hi;
    logic signed [SpeedW-1:0] lo;
    hi = signed'({1'b0, lim});
    lo = -hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  logic                     v1;
  logic signed [SpeedW-1:0] vx1, vy1, vw1;
  logic                     v2;
  logic signed [32:0]       rot2;
  logic signed [17:0]       lin2 [WheelN];
  logic                     v3;
  logic [31:0]              m3 [WheelN];
  logic [WheelN-1:0]        neg3;
  logic signed [17:0]       lin_next [WheelN];
  logic signed [33:0]       sum [WheelN];
  logic signed [33:0]       abs_sum [WheelN];
  logic [55:0]              prod [WheelN];
  logic signed [17:0]       vxe, vye;

  assign vxe = 18'(vx1);
  assign vye = 18'(vy1);

  always_comb begin
    lin_next[0] = -vxe - vye;
    lin_next[1] =  vxe - vye;
    lin_next[2] =  vxe + vye;
    lin_next[3] = -vxe + vye;
    for (int i = 0; i < WheelN; i++) begin
      sum[i]     = 34'(signed'({lin2[i], 8'b0})) + 34'(rot2);
      abs_sum[i] = sum[i][33] ? -sum[i] : sum[i];
      prod[i]    = 56'(m3[i]) * 56'(cfg.rpm_ratio);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      mag_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      mag_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    vx1  <= clamp_sym(cmd.speed_sideways, cfg.limit_sideways);
    vy1  <= clamp_sym(cmd.speed_forward, cfg.limit_forward);
    vw1  <= clamp_sym(cmd.speed_rotation, cfg.limit_rotation);
    rot2 <= 33'(vw1) * 33'(signed'({1'b0, cfg.rotate_ratio}));
    for (int i = 0; i < WheelN; i++) begin
      lin2[i] <= lin_next[i];
      m3[i]   <= abs_sum[i][31:0];
      neg3[i] <= sum[i][33];
      mag[i]  <= prod[i][55:32];
      neg[i]  <= neg3[i];
    end
  end

endmodule

// ----- rtl/mwsm_norm.sv -----
// Largest-wheel search and scale numerator stages of the mecanum speed mixer.
module mwsm_norm
  import mwsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              mag_valid,
  input  logic [MagW-1:0]   mag [WheelN],
  input  logic [WheelN-1:0] neg,
  input  logic [LimitW-1:0] rpm_cap,
  output logic              num_valid,
  output logic [NumW-1:0]   num [WheelN],
  output logic [MagW-1:0]   den,
  output logic [WheelN-1:0] num_neg
);

  logic              v5, v6;
  logic [MagW-1:0]   pair5 [2];
  logic [MagW-1:0]   mag5 [WheelN];
  logic [MagW-1:0]   mag6 [WheelN];
  logic [WheelN-1:0] neg5, neg6;
  logic [LimitW-1:0] factor6;
  logic [MagW-1:0]   den6;
  logic [MagW-1:0]   largest;
  logic              scale;

  assign largest = (pair5[0] > pair5[1]) ? pair5[0] : pair5[1];
  assign scale   = largest > MagW'(rpm_cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      num_valid <= 1'b0;
    end else begin
      v5        <= mag_valid;
      v6        <= v5;
      num_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    pair5[0] <= (mag[0] > mag[1]) ? mag[0] : mag[1];
    pair5[1] <= (mag[2] > mag[3]) ? mag[2] : mag[3];
    neg5     <= neg;
    neg6     <= neg5;
    num_neg  <= neg6;
    factor6  <= scale ? rpm_cap : LimitW'(1);
    den6     <= scale ? largest : MagW'(1);
    den      <= den6;
    for (int i = 0; i < WheelN; i++) begin
      mag5[i] <= mag[i];
      mag6[i] <= mag5[i];
      num[i]  <= NumW'(mag6[i]) * NumW'(factor6);
    end
  end

endmodule

// ----- rtl/mwsm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for one wheel.
module mwsm_div
  import mwsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NumW-1:0]  num,
  input  logic [MagW-1:0]  den,
  input  logic             in_neg,
  output logic             out_valid,
  output logic [QuotW-1:0] quot,
  output logic             out_neg
);

  logic [QuotW-1:0] vld;
  logic [MagW-1:0]  rem_q [QuotW];
  logic [QuotW-1:0] low_q [QuotW];
  logic [QuotW-1:0] quo_q [QuotW];
  logic [MagW-1:0]  den_q [QuotW];
  logic [QuotW-1:0] neg_q;

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic            v_in;
    logic [MagW-1:0] rem_in;
    logic [QuotW-1:0] low_in;
    logic [QuotW-1:0] quo_in;
    logic [MagW-1:0] den_in;
    logic            neg_in;
    logic [MagW:0]   trial;
    logic            fits;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = num[NumW-1:QuotW];
      assign low_in = num[QuotW-1:0];
      assign quo_in = '0;
      assign den_in = den;
      assign neg_in = in_neg;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign trial = {rem_in, low_in[QuotW-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= fits ? MagW'(trial - {1'b0, den_in}) : trial[MagW-1:0];
      low_q[k] <= {low_in[QuotW-2:0], 1'b0};
      quo_q[k] <= {quo_in[QuotW-2:0], fits};
      den_q[k] <= den_in;
      neg_q[k] <= neg_in;
    end
  end

  assign out_valid = vld[QuotW-1];
  assign quot      = quo_q[QuotW-1];
  assign out_neg   = neg_q[QuotW-1];

endmodule
